// File: sv/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types, codes and helpers for the route segment sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

    // Default table depth
    localparam int DEF_MAX_SEGMENTS = 16;

    // Field widths
    localparam int CUR_W  = 5;
    localparam int SLOT_W = 4;
    localparam int MASK_W = 16;
    localparam int TIME_W = 32;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_rstate;
    typedef logic [2:0] t_kind;
    typedef logic [3:0] t_action;

    // Item modes
    localparam t_mode MODE_LOAD  = 2'd0;
    localparam t_mode MODE_START = 2'd1;
    localparam t_mode MODE_STOP  = 2'd2;
    localparam t_mode MODE_TICK  = 2'd3;

    // Route states
    localparam t_rstate ST_IDLE  = 2'd0;
    localparam t_rstate ST_RUN   = 2'd1;
    localparam t_rstate ST_DONE  = 2'd2;
    localparam t_rstate ST_FAULT = 2'd3;

    // Segment kinds
    localparam t_kind K_FOLLOW   = 3'd0;
    localparam t_kind K_STRAIGHT = 3'd1;
    localparam t_kind K_TURN     = 3'd2;
    localparam t_kind K_ARC      = 3'd3;

    // Actions
    localparam t_action ACT_NONE         = 4'd0;
    localparam t_action ACT_START_FOLLOW = 4'd1;
    localparam t_action ACT_START_STRT   = 4'd2;
    localparam t_action ACT_START_TURN   = 4'd3;
    localparam t_action ACT_START_ARC    = 4'd4;
    localparam t_action ACT_UPD_FOLLOW   = 4'd5;
    localparam t_action ACT_UPD_MOTION   = 4'd6;
    localparam t_action ACT_STOP_FOLLOW  = 4'd7;
    localparam t_action ACT_STOP_MOTION  = 4'd8;

    // Stop command that matches a segment kind
    function automatic t_action stop_action(input t_kind kind);
        return (kind == K_FOLLOW) ? ACT_STOP_FOLLOW : ACT_STOP_MOTION;
    endfunction

    // Start command for a motion kind (straight, turn, arc)
    function automatic t_action start_action(input t_kind kind);
        return ACT_START_FOLLOW + t_action'(kind);
    endfunction

endpackage

`default_nettype wire

// File: sv/route_segment_sequencer.sv
// ----------------------------------------------------------------------------
// route_segment_sequencer
// Walks a table of route segments and issues start, update and stop commands
// for the host's line and motion services, one action word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Output: an item passes the input register, then its first result word is
//   loaded into the result holder once the holder is free.
// Throughput: one item per cycle while each item yields one word and the output
//   is not stalled; an item that yields several words (up to 3) holds the input
//   until the single output port has drained them, one word per take.
// Reset: synchronous active-low; route idle, index 0, count 0. The segment
//   table is not cleared and holds garbage until loaded.
`default_nettype none

module route_segment_sequencer
    import rss_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,

    // Configuration write
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [CUR_W-1:0]    i_cfg_data,

    // Input words
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  [1:0]          i_mode,
    input  wire  [SLOT_W-1:0]   i_entry_index,
    input  wire  [2:0]          i_entry_kind,
    input  wire  [MASK_W-1:0]   i_entry_until_mask,
    input  wire  [TIME_W-1:0]   i_entry_timeout_ms,
    input  wire  [TIME_W-1:0]   i_now_ms,
    input  wire                 i_start_ok,
    input  wire                 i_motion_done,
    input  wire  [MASK_W-1:0]   i_line_events,
    input  wire                 i_line_lost,

    // Result words
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic [3:0]          o_action,
    output logic [1:0]          o_seq_state,
    output logic [3:0]          o_seq_index,
    output logic [2:0]          o_seq_kind,
    output logic                o_last
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic                r_in_valid;
    t_mode               r_in_mode;
    logic [SLOT_W-1:0]   r_in_slot;
    t_kind               r_in_kind;
    logic [MASK_W-1:0]   r_in_mask;
    logic [TIME_W-1:0]   r_in_timeout;
    logic [TIME_W-1:0]   r_in_now;
    logic                r_in_start_ok;
    logic                r_in_motion_done;
    logic [MASK_W-1:0]   r_in_events;
    logic                r_in_lost;

    logic [CUR_W-1:0]    r_count;
    t_rstate             r_state;
    logic [CUR_W-1:0]    r_cur;
    logic                r_ent;
    logic [TIME_W-1:0]   r_base;

    t_action             r_act [3];
    logic [1:0]          r_num;

    // Table and its registered read ports
    t_kind               mem_kind    [MAX_SEGMENTS];
    logic [MASK_W-1:0]   mem_mask    [MAX_SEGMENTS];
    logic [TIME_W-1:0]   mem_timeout [MAX_SEGMENTS];
    t_kind               r_cur_kind;
    logic [MASK_W-1:0]   r_cur_mask;
    logic [TIME_W-1:0]   r_cur_timeout;
    t_kind               r_tel_kind;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic                in_accept;
    logic                out_take;
    logic                hold_free;
    logic                fire;

    logic [CUR_W-1:0]    cnt_eff;
    logic [CUR_W-1:0]    n_count;
    logic [CUR_W-1:0]    n_cnt_eff;
    t_rstate             n_state;
    logic [CUR_W-1:0]    n_cur;
    logic                n_ent;
    logic [TIME_W-1:0]   n_base;
    t_action             n_act [3];
    logic [1:0]          n_num;
    logic                ok;
    logic                seg_done;
    logic                time_up;
    logic [TIME_W-1:0]   elapsed;
    logic [CUR_W-1:0]    cur_inc;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [CUR_W-1:0]    rd_cur;
    logic                rd_cur_ok;
    logic [AW-1:0]       rd_cur_addr;
    logic [CUR_W-1:0]    rd_tel;
    logic [AW-1:0]       rd_tel_addr;
    logic [CUR_W-1:0]    tel_idx;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign out_take    = o_out_valid && !i_out_stall;
    assign hold_free   = (r_num == 2'd0) || ((r_num == 2'd1) && !i_out_stall);
    assign fire        = r_in_valid && hold_free;
    assign o_in_stall  = r_in_valid && !hold_free;
    assign in_accept   = i_in_valid && !o_in_stall;

    // Clamp count to table depth
    function automatic logic [CUR_W-1:0] clamp_count(input logic [CUR_W-1:0] c);
        return (32'(c) > 32'(MAX_SEGMENTS)) ? CUR_W'(MAX_SEGMENTS) : c;
    endfunction

    // Clamp an index into the valid part of the table
    function automatic logic [CUR_W-1:0] clamp_index(input logic [CUR_W-1:0] idx,
                                                     input logic [CUR_W-1:0] c);
        if (c == '0) begin
            return '0;
        end else if (idx >= c) begin
            return c - CUR_W'(1);
        end else begin
            return idx;
        end
    endfunction

    assign n_count   = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_count;
    assign cnt_eff   = clamp_count(r_count);
    assign n_cnt_eff = clamp_count(n_count);
    assign elapsed   = r_in_now - r_base;
    assign cur_inc   = r_cur + CUR_W'(1);

    // ------------------------------------------------------------------
    // Item processing
    // ------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_ent    = r_ent;
        n_base   = r_base;
        n_act[0] = ACT_NONE;
        n_act[1] = ACT_NONE;
        n_act[2] = ACT_NONE;
        n_num    = 2'd0;
        ok       = 1'b0;
        seg_done = 1'b0;
        time_up  = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = AW'(r_in_slot);

        if (fire) begin
            case (r_in_mode)
                MODE_LOAD: begin
                    wr_en = (r_state != ST_RUN) && (32'(r_in_slot) < 32'(MAX_SEGMENTS));
                end
                MODE_START: begin
                    n_cur   = '0;
                    n_ent   = 1'b0;
                    n_state = (cnt_eff == '0) ? ST_DONE : ST_RUN;
                end
                MODE_STOP: begin
                    if (r_state == ST_RUN && r_ent) begin
                        n_act[0] = stop_action(r_cur_kind);
                        n_num    = 2'd1;
                    end
                    n_state = ST_IDLE;
                end
                default: begin
                    if (r_state == ST_RUN) begin
                        if (r_cur >= cnt_eff) begin
                            // count shrank to or below the index
                            n_state = ST_DONE;
                            n_ent   = 1'b0;
                        end else if (!r_ent) begin
                            // entry tick: start commands (motion gets an update first), stop if refused
                            if (r_cur_kind == K_FOLLOW) begin
                                n_act[n_num] = ACT_START_FOLLOW;
                                n_num        = n_num + 2'd1;
                                ok           = r_in_start_ok;
                            end else if (r_cur_kind <= K_ARC) begin
                                n_act[n_num] = ACT_UPD_MOTION;
                                n_num        = n_num + 2'd1;
                                n_act[n_num] = start_action(r_cur_kind);
                                n_num        = n_num + 2'd1;
                                ok           = r_in_start_ok;
                            end
                            if (ok) begin
                                n_base = r_in_now;
                                n_ent  = 1'b1;
                            end else begin
                                n_act[n_num] = stop_action(r_cur_kind);
                                n_num        = n_num + 2'd1;
                                n_state      = ST_FAULT;
                            end
                        end else begin
                            // drive the active service and test completion
                            if (r_cur_kind == K_FOLLOW) begin
                                n_act[n_num] = ACT_UPD_FOLLOW;
                                seg_done     = |(r_in_events & r_cur_mask);
                            end else begin
                                n_act[n_num] = ACT_UPD_MOTION;
                                seg_done     = r_in_motion_done;
                            end
                            n_num   = n_num + 2'd1;
                            time_up = (r_cur_timeout != '0) && (elapsed >= r_cur_timeout);
                            if (seg_done) begin
                                if (r_cur_kind == K_FOLLOW) begin
                                    n_act[n_num] = ACT_STOP_FOLLOW;
                                    n_num        = n_num + 2'd1;
                                end
                                n_cur = cur_inc;
                                n_ent = 1'b0;
                                if (cur_inc >= cnt_eff) begin
                                    n_state = ST_DONE;
                                end
                            end else if ((r_cur_kind == K_FOLLOW && r_in_lost) || time_up) begin
                                n_act[n_num] = stop_action(r_cur_kind);
                                n_num        = n_num + 2'd1;
                                n_state      = ST_FAULT;
                            end
                        end
                    end
                end
            endcase
            // every item yields at least one word
            if (n_num == 2'd0) begin
                n_num = 2'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Table read addresses: follow the next index and telemetry index
    // ------------------------------------------------------------------
    assign rd_cur      = i_rst_n ? n_cur : '0;
    assign rd_cur_ok   = 32'(rd_cur) < 32'(MAX_SEGMENTS);
    assign rd_cur_addr = AW'(rd_cur);
    assign rd_tel      = i_rst_n ? clamp_index(n_cur, n_cnt_eff) : '0;
    assign rd_tel_addr = AW'(rd_tel);

    // Write the table on a load
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_kind[wr_addr]    <= r_in_kind;
            mem_mask[wr_addr]    <= r_in_mask;
            mem_timeout[wr_addr] <= r_in_timeout;
        end
    end

    // Read current segment entry, with write forwarding
    always_ff @(posedge i_clk) begin
        if (!rd_cur_ok) begin
            r_cur_kind    <= K_FOLLOW;
            r_cur_mask    <= '0;
            r_cur_timeout <= '0;
        end else if (wr_en && wr_addr == rd_cur_addr) begin
            r_cur_kind    <= r_in_kind;
            r_cur_mask    <= r_in_mask;
            r_cur_timeout <= r_in_timeout;
        end else begin
            r_cur_kind    <= mem_kind[rd_cur_addr];
            r_cur_mask    <= mem_mask[rd_cur_addr];
            r_cur_timeout <= mem_timeout[rd_cur_addr];
        end
    end

    // Read telemetry kind, with write forwarding
    always_ff @(posedge i_clk) begin
        if (wr_en && wr_addr == rd_tel_addr) begin
            r_tel_kind <= r_in_kind;
        end else begin
            r_tel_kind <= mem_kind[rd_tel_addr];
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_mode        <= i_mode;
            r_in_slot        <= i_entry_index;
            r_in_kind        <= i_entry_kind;
            r_in_mask        <= i_entry_until_mask;
            r_in_timeout     <= i_entry_timeout_ms;
            r_in_now         <= i_now_ms;
            r_in_start_ok    <= i_start_ok;
            r_in_motion_done <= i_motion_done;
            r_in_events      <= i_line_events;
            r_in_lost        <= i_line_lost;
        end
    end

    // ------------------------------------------------------------------
    // Route state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_state <= ST_IDLE;
            r_cur   <= '0;
            r_ent   <= 1'b0;
            r_base  <= '0;
        end else begin
            r_count <= n_count;
            r_state <= n_state;
            r_cur   <= n_cur;
            r_ent   <= n_ent;
            r_base  <= n_base;
        end
    end

    // ------------------------------------------------------------------
    // Result holder: load on fire, advance one word per take
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= 2'd0;
        end else if (fire) begin
            r_num <= n_num;
        end else if (out_take) begin
            r_num <= r_num - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_act[0] <= n_act[0];
            r_act[1] <= n_act[1];
            r_act[2] <= n_act[2];
        end else if (out_take) begin
            r_act[0] <= r_act[1];
            r_act[1] <= r_act[2];
        end
    end

    // ------------------------------------------------------------------
    // Outputs: telemetry comes from the state left by the item
    // ------------------------------------------------------------------
    assign tel_idx     = clamp_index(r_cur, cnt_eff);
    assign o_out_valid = (r_num != 2'd0);
    assign o_action    = r_act[0];
    assign o_last      = (r_num == 2'd1);
    assign o_seq_state = r_state;
    assign o_seq_index = tel_idx[3:0];
    assign o_seq_kind  = (cnt_eff == '0) ? K_FOLLOW : r_tel_kind;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a processed item always shows a word next cycle
    a_fire_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("processed item produced no result word");

    // a non-final word taken leaves the next word of the same item
    a_drain_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && !o_last) |=> o_out_valid)
        else $error("result words of one item were split");

    // an entered segment is driven, never restarted
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_mode == MODE_TICK && r_state == ST_RUN && r_ent
         && r_cur < cnt_eff)
        |=> (o_action == ACT_UPD_FOLLOW || o_action == ACT_UPD_MOTION))
        else $error("entered segment did not get an update first");

    // entry of a follow segment opens with a start follow
    a_entry_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_mode == MODE_TICK && r_state == ST_RUN && !r_ent
         && r_cur < cnt_eff && r_cur_kind == K_FOLLOW)
        |=> (o_action == ACT_START_FOLLOW))
        else $error("follow entry did not start the follower");

endmodule

`default_nettype wire
